/* sv/nmt_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest marker tracker package
// Shared widths and register indexes.
// ----------------------------------------------------------------------------
package nmt_pkg;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 12;
   localparam int INDEX_BITS    = 4;
   localparam int JITTER_BITS   = 12;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_JITTER    = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SMOOTHING = 1'b1;
endpackage

/* sv/nmt_point_if.sv */
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel that carries one detected point.
// ----------------------------------------------------------------------------
interface nmt_point_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   modport source (output valid, point_x, point_y, input ready);
   modport sink   (input valid, point_x, point_y, output ready);
endinterface

/* sv/nmt_index_if.sv */
// ----------------------------------------------------------------------------
// Index channel
// Valid/ready channel that carries one marker index.
// ----------------------------------------------------------------------------
interface nmt_index_if;
   logic       valid;
   logic       ready;
   logic [3:0] marker_index;
   modport source (output valid, marker_index, input ready);
   modport sink   (input valid, marker_index, output ready);
endinterface

/* sv/nmt_cell.sv */
// ----------------------------------------------------------------------------
// Marker cell
// Holds one marker's positions. The point passes through the chain and starts
// each cell's floored-root unit; a best token follows behind the point, and
// each cell compares its root with the best so far and forwards the winner.
// A write strobe updates the cell.
// ----------------------------------------------------------------------------
module nmt_cell
   import nmt_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int IDX_BITS   = 4,
   parameter logic [IDX_BITS-1:0] MY_INDEX = '0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [COORD_BITS-1:0]   in_x,
   input  logic [COORD_BITS-1:0]   in_y,
   output logic                    out_valid,
   output logic [COORD_BITS-1:0]   out_x,
   output logic [COORD_BITS-1:0]   out_y,
   input  logic                    in_bvalid,
   input  logic                    in_have,
   input  logic [COORD_BITS:0]     in_best,
   input  logic [IDX_BITS-1:0]     in_idx,
   output logic                    out_bvalid,
   output logic                    out_have,
   output logic [COORD_BITS:0]     out_best,
   output logic [IDX_BITS-1:0]     out_idx,
   input  logic                    wr_en,
   input  logic [IDX_BITS-1:0]     wr_idx,
   input  logic [COORD_BITS-1:0]   wr_x,
   input  logic [COORD_BITS-1:0]   wr_y,
   output logic [COORD_BITS-1:0]   cur_x,
   output logic [COORD_BITS-1:0]   cur_y,
   output logic [COORD_BITS-1:0]   prv_x,
   output logic [COORD_BITS-1:0]   prv_y
);
   localparam int SQ_BITS   = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS = COORD_BITS + 1;

   logic [COORD_BITS-1:0] cx_ff, cy_ff, px_ff, py_ff;
   logic [COORD_BITS-1:0] dx, dy;
   logic [SQ_BITS-1:0]    d_sq;
   logic [ROOT_BITS-1:0]  my_root;
   logic                  take;
   logic                  v_ff, bv_ff, have_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [ROOT_BITS-1:0]  best_ff;
   logic [IDX_BITS-1:0]   idx_ff;

   assign dx = (in_x > cx_ff) ? in_x - cx_ff : cx_ff - in_x;
   assign dy = (in_y > cy_ff) ? in_y - cy_ff : cy_ff - in_y;
   assign d_sq = SQ_BITS'(dx) * SQ_BITS'(dx) + SQ_BITS'(dy) * SQ_BITS'(dy);

   nmt_root #(.SQ_BITS(SQ_BITS), .ROOT_BITS(ROOT_BITS)) u_root (
      .clock (clock),
      .reset (reset),
      .start (in_valid),
      .value (d_sq),
      .root  (my_root)
   );

   // Strict compare of floored roots keeps the lower index on a tie.
   assign take = !in_have || (my_root < in_best);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 1'b0;
         bv_ff <= 1'b0;
         cx_ff <= '0;
         cy_ff <= '0;
         px_ff <= '0;
         py_ff <= '0;
      end else begin
         v_ff  <= in_valid;
         bv_ff <= in_bvalid;
         if (wr_en && (wr_idx == MY_INDEX)) begin
            px_ff <= cx_ff;
            py_ff <= cy_ff;
            cx_ff <= wr_x;
            cy_ff <= wr_y;
         end
      end
      x_ff    <= in_x;
      y_ff    <= in_y;
      have_ff <= 1'b1;
      best_ff <= take ? my_root : in_best;
      idx_ff  <= take ? MY_INDEX : in_idx;
   end

   assign out_valid  = v_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_bvalid = bv_ff;
   assign out_have   = have_ff;
   assign out_best   = best_ff;
   assign out_idx    = idx_ff;
   assign cur_x      = cx_ff;
   assign cur_y      = cy_ff;
   assign prv_x      = px_ff;
   assign prv_y      = py_ff;
endmodule

/* sv/nearest_marker_tracker_unit.sv */
// ----------------------------------------------------------------------------
// Nearest marker tracker
// ----------------------------------------------------------------------------
// One point is taken at a time. It walks a chain of NUM_MARKERS cells, one
// cell per cycle, and starts in each cell a floored square root of that
// marker's squared distance, worked out one bit per cycle. A best token
// follows behind the point and meets every root once it is ready; a later
// cell wins only if its floored root is strictly smaller, so ties in floored
// distance go to the lower index. The chosen marker is then updated and its
// index offered; the next point is taken only once that index has been
// accepted, so the time per point is set by the cell chain, the root unit and
// any stall on the result side.
// ----------------------------------------------------------------------------
module nearest_marker_tracker_unit
   import nmt_pkg::*;
#(
   parameter int NUM_MARKERS = 16,
   parameter int COORD_BITS  = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   nmt_point_if.sink                req,
   nmt_index_if.source              rsp,
   input  logic                     csr_write_enable,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);
   localparam int IDX_BITS  = (NUM_MARKERS > 1) ? $clog2(NUM_MARKERS) : 1;
   localparam int SQ_BITS   = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS = COORD_BITS + 1;
   // Division by three as a reciprocal multiply; exact for sums below
   // 2**(COORD_BITS+2).
   localparam int DIV_SHIFT = COORD_BITS + 4;
   localparam int PROD_BITS = 2 * COORD_BITS + 6;
   localparam logic [PROD_BITS-1:0] DIV3_RECIP = PROD_BITS'((2**DIV_SHIFT + 2) / 3);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ROOT, S_CALC, S_DONE} state_type;

   state_type               state_ff;
   logic [JITTER_BITS-1:0]  jitter_ff;
   logic                    smooth_ff;
   logic [COORD_BITS-1:0]   px_ff, py_ff;
   logic                    launch_ff;
   logic [ROOT_BITS:0]      launch_dly_ff;
   logic [3:0]              out_idx_ff;
   logic                    rsp_valid_ff;
   logic [IDX_BITS-1:0]     win_ff;
   logic [COORD_BITS-1:0]   newx_ff, newy_ff;
   logic                    wr_en_ff;

   logic                    cv   [NUM_MARKERS+1];
   logic [COORD_BITS-1:0]   cxs  [NUM_MARKERS+1];
   logic [COORD_BITS-1:0]   cys  [NUM_MARKERS+1];
   logic                    cbv  [NUM_MARKERS+1];
   logic                    chv  [NUM_MARKERS+1];
   logic [ROOT_BITS-1:0]    cbst [NUM_MARKERS+1];
   logic [IDX_BITS-1:0]     cidx [NUM_MARKERS+1];
   logic [COORD_BITS-1:0]   cur_x [NUM_MARKERS];
   logic [COORD_BITS-1:0]   cur_y [NUM_MARKERS];
   logic [COORD_BITS-1:0]   prv_x [NUM_MARKERS];
   logic [COORD_BITS-1:0]   prv_y [NUM_MARKERS];

   assign cv[0]   = launch_ff;
   assign cxs[0]  = px_ff;
   assign cys[0]  = py_ff;
   assign cbv[0]  = launch_dly_ff[ROOT_BITS];
   assign chv[0]  = 1'b0;
   assign cbst[0] = '0;
   assign cidx[0] = '0;

   genvar g;
   generate
      for (g = 0; g < NUM_MARKERS; g++) begin : g_cell
         nmt_cell #(
            .COORD_BITS (COORD_BITS),
            .IDX_BITS   (IDX_BITS),
            .MY_INDEX   (IDX_BITS'(g))
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (cv[g]),
            .in_x       (cxs[g]),
            .in_y       (cys[g]),
            .out_valid  (cv[g+1]),
            .out_x      (cxs[g+1]),
            .out_y      (cys[g+1]),
            .in_bvalid  (cbv[g]),
            .in_have    (chv[g]),
            .in_best    (cbst[g]),
            .in_idx     (cidx[g]),
            .out_bvalid (cbv[g+1]),
            .out_have   (chv[g+1]),
            .out_best   (cbst[g+1]),
            .out_idx    (cidx[g+1]),
            .wr_en      (wr_en_ff),
            .wr_idx     (win_ff),
            .wr_x       (newx_ff),
            .wr_y       (newy_ff),
            .cur_x      (cur_x[g]),
            .cur_y      (cur_y[g]),
            .prv_x      (prv_x[g]),
            .prv_y      (prv_y[g])
         );
      end
   endgenerate

   // Update arithmetic for the chosen marker.
   logic [COORD_BITS-1:0] wcx, wcy, wpx, wpy, adx, ady;
   logic [SQ_BITS-1:0]    wd_sq;
   logic [2*JITTER_BITS-1:0] j_sq;
   logic [COORD_BITS+1:0] sx, sy;
   logic [PROD_BITS-1:0]  sx_prod, sy_prod;
   logic [COORD_BITS+1:0] ax, ay;
   logic [COORD_BITS-1:0] nx, ny;

   assign wcx = cur_x[win_ff];
   assign wcy = cur_y[win_ff];
   assign wpx = prv_x[win_ff];
   assign wpy = prv_y[win_ff];
   assign adx = (px_ff > wcx) ? px_ff - wcx : wcx - px_ff;
   assign ady = (py_ff > wcy) ? py_ff - wcy : wcy - py_ff;
   assign wd_sq = SQ_BITS'(adx) * SQ_BITS'(adx) + SQ_BITS'(ady) * SQ_BITS'(ady);
   assign j_sq  = jitter_ff * jitter_ff;
   assign sx = {2'b0, wpx} + {2'b0, wcx} + {2'b0, px_ff};
   assign sy = {2'b0, wpy} + {2'b0, wcy} + {2'b0, py_ff};
   assign sx_prod = PROD_BITS'(sx) * DIV3_RECIP;
   assign sy_prod = PROD_BITS'(sy) * DIV3_RECIP;
   assign ax = sx_prod[DIV_SHIFT +: COORD_BITS+2];
   assign ay = sy_prod[DIV_SHIFT +: COORD_BITS+2];

   always_comb begin
      nx = px_ff;
      ny = py_ff;
      if (!smooth_ff && jitter_ff != '0) begin
         if ({{(2*JITTER_BITS+1){1'b0}}, wd_sq} < {{SQ_BITS{1'b0}}, 1'b0, j_sq}) begin
            nx = wcx;
            ny = wcy;
         end
      end else if (smooth_ff && wpx != '0 && wpy != '0 && ax != '0 && ay != '0) begin
         nx = ax[COORD_BITS-1:0];
         ny = ay[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         jitter_ff     <= '0;
         smooth_ff     <= 1'b0;
         launch_ff     <= 1'b0;
         launch_dly_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         wr_en_ff      <= 1'b0;
      end else begin
         launch_ff     <= (state_ff == S_IDLE) && req.valid;
         launch_dly_ff <= {launch_dly_ff[ROOT_BITS-1:0], launch_ff};
         wr_en_ff      <= (state_ff == S_CALC);
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_JITTER:    jitter_ff <= csr_write_data[JITTER_BITS-1:0];
               CSR_SMOOTHING: smooth_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  px_ff    <= req.point_x;
                  py_ff    <= req.point_y;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (cbv[NUM_MARKERS]) begin
                  win_ff   <= cidx[NUM_MARKERS];
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               newx_ff  <= nx;
               newy_ff  <= ny;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               out_idx_ff   <= 4'(win_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_DONE;
            end
            S_DONE: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.marker_index = out_idx_ff;

   a_one_owner: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("result pending while accepting");
   a_write_once: assert property (@(posedge clock) disable iff (reset)
      wr_en_ff |=> !wr_en_ff)
      else $error("double marker update");
   a_launch: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> launch_ff)
      else $error("scan not launched");
endmodule

/* sv/nmt_root.sv */
// ----------------------------------------------------------------------------
// Integer square root
// Floor root of a squared distance, worked out one result bit per cycle
// by shift, compare and subtract.
// ----------------------------------------------------------------------------
module nmt_root #(
   parameter int SQ_BITS   = 25,
   parameter int ROOT_BITS = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_BITS-1:0]   value,
   output logic [ROOT_BITS-1:0] root
);
   localparam int WORK_BITS = 2 * ROOT_BITS + 1;

   logic [WORK_BITS-1:0] rem_ff, res_ff, bit_ff;
   logic [WORK_BITS-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         res_ff <= '0;
         bit_ff <= '0;
      end else if (start) begin
         rem_ff <= WORK_BITS'(value);
         res_ff <= '0;
         bit_ff <= WORK_BITS'(1) << (2 * (ROOT_BITS - 1));
      end else if (bit_ff != '0) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = res_ff[ROOT_BITS-1:0];
endmodule

/* bench/nmt_marker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Marker tracker checker
// Watches the point and index channels, keeps its own copy of the marker
// table and compares every returned index with the predicted one.
// ----------------------------------------------------------------------------
module nmt_marker_checker
   import nmt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [11:0]              req_point_x,
   input  logic [11:0]              req_point_y,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [3:0]               rsp_marker_index,
   input  logic                     csr_write_enable,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   output int                       fail_count,
   output int                       pending_count
);
   logic [11:0] cur_x [16];
   logic [11:0] cur_y [16];
   logic [11:0] prev_x [16];
   logic [11:0] prev_y [16];
   logic [11:0] jitter;
   logic        smoothing;
   logic [3:0]  index_queue [$];

   function automatic longint unsigned sq_distance(logic [11:0] ax, logic [11:0] ay,
                                                   logic [11:0] bx, logic [11:0] by);
      longint unsigned dx;
      longint unsigned dy;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      return dx * dx + dy * dy;
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   // Picks the nearest marker, updates it and returns its index.
   function automatic logic [3:0] track_point(logic [11:0] px_in, logic [11:0] py_in);
      longint unsigned best;
      longint unsigned d;
      logic [11:0] px;
      logic [11:0] py;
      logic [13:0] ax;
      logic [13:0] ay;
      int n;
      px = px_in;
      py = py_in;
      ax = 0;
      ay = 0;
      n = 0;
      best = floor_root(sq_distance(px, py, cur_x[0], cur_y[0]));
      for (int i = 1; i < 16; i++) begin
         d = floor_root(sq_distance(px, py, cur_x[i], cur_y[i]));
         if (d < best) begin
            best = d;
            n = i;
         end
      end
      if (jitter != 0 && !smoothing) begin
         if (sq_distance(cur_x[n], cur_y[n], px, py) < longint'(jitter) * jitter) begin
            px = cur_x[n];
            py = cur_y[n];
         end
      end else if (smoothing) begin
         if (prev_x[n] != 0 && prev_y[n] != 0) begin
            ax = (14'(prev_x[n]) + cur_x[n] + px) / 3;
            ay = (14'(prev_y[n]) + cur_y[n] + py) / 3;
         end
      end
      prev_x[n] = cur_x[n];
      prev_y[n] = cur_y[n];
      if (ax != 0 && ay != 0) begin
         cur_x[n] = ax[11:0];
         cur_y[n] = ay[11:0];
      end else begin
         cur_x[n] = px;
         cur_y[n] = py;
      end
      return 4'(n);
   endfunction

   assign pending_count = index_queue.size();

   always @(posedge clock) begin
      logic [3:0] expected;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            cur_x[i] <= 0;
            cur_y[i] <= 0;
            prev_x[i] <= 0;
            prev_y[i] <= 0;
         end
         jitter <= 0;
         smoothing <= 0;
         fail_count <= 0;
         index_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_JITTER) jitter = csr_write_data;
            else if (csr_index == CSR_SMOOTHING) smoothing = csr_write_data[0];
         end
         if (req_valid && req_ready) index_queue.push_back(track_point(req_point_x, req_point_y));
         if (rsp_valid && rsp_ready) begin
            if (index_queue.size() == 0) begin
               $display("%0t: unexpected index transaction, actual %0d", $time,
                        rsp_marker_index);
               fail_count <= fail_count + 1;
            end else begin
               expected = index_queue.pop_front();
               if (expected !== rsp_marker_index) begin
                  $display("%0t: marker_index expected %0d actual %0d", $time, expected,
                           rsp_marker_index);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* bench/tb_nearest_marker_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest marker tracker testbench
// Drives directed and random points through several register settings with
// random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_nearest_marker_tracker_unit;
   import nmt_pkg::*;

   localparam longint CYCLE_LIMIT = 1000000;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     csr_write_enable = 0;
   logic [CSR_ADDR_BITS-1:0] csr_index = CSR_JITTER;
   logic [CSR_DATA_BITS-1:0] csr_write_data = 0;
   int                       fail_count;
   int                       pending_count;
   longint                   cycle_count = 0;
   logic [11:0]              anchor_x;
   logic [11:0]              anchor_y;

   nmt_point_if #(.COORD_BITS(12)) req ();
   nmt_index_if rsp ();

   always #1 clock = ~clock;

   nearest_marker_tracker_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   nmt_marker_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_point_x(req.point_x), .req_point_y(req.point_y),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_marker_index(rsp.marker_index),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // The result side stalls in phases so that some stretches never stall.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else if (cycle_count % 3000 < 600) rsp.ready <= 1;
      else rsp.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 40) == 0);
   end

   // Valid stays up after acceptance until the next point or a drain, so a
   // back-to-back point needs only one assignment at that edge.
   task automatic send_point(logic [11:0] x, logic [11:0] y);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.point_x <= x;
      req.point_y <= y;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      req.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Mostly points near a moving anchor so markers get tracked and smoothed.
   task automatic random_points(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: send_point(12'($urandom), 12'($urandom));
            1: send_point(anchor_x, anchor_y);
            default: begin
               anchor_x = anchor_x + 12'($urandom_range(0, 16)) - 12'd8;
               anchor_y = anchor_y + 12'($urandom_range(0, 16)) - 12'd8;
               if ($urandom_range(0, 15) == 0) begin
                  anchor_x = 12'($urandom);
                  anchor_y = 12'($urandom);
               end
               send_point(anchor_x, anchor_y);
            end
         endcase
      end
   endtask

   initial begin
      req.valid = 0;
      req.point_x = 0;
      req.point_y = 0;
      anchor_x = 12'd2000;
      anchor_y = 12'd1000;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: extremes, ties at reset, snapping and smoothing corners.
      send_point(12'd0, 12'd0);
      send_point(12'd4095, 12'd4095);
      send_point(12'd4095, 12'd0);
      send_point(12'd0, 12'd4095);
      send_point(12'd1, 12'd1);
      send_point(12'd2048, 12'd2048);
      drain_results();
      write_csr(CSR_JITTER, 12'd4095);
      send_point(12'd100, 12'd100);
      send_point(12'd4095, 12'd4095);
      send_point(12'd4094, 12'd4093);
      drain_results();
      write_csr(CSR_JITTER, 12'd5);
      send_point(12'd2050, 12'd2051);
      send_point(12'd2060, 12'd2048);
      drain_results();
      write_csr(CSR_SMOOTHING, 12'd1);
      send_point(12'd1, 12'd1);
      send_point(12'd1, 12'd1);
      send_point(12'd0, 12'd0);
      send_point(12'd4095, 12'd4095);
      send_point(12'd4095, 12'd4095);
      send_point(12'd4095, 12'd4095);
      send_point(12'd2, 12'd0);
      drain_results();
      write_csr(CSR_SMOOTHING, 12'd0);
      write_csr(CSR_JITTER, 12'd0);
      random_points(300);
      drain_results();
      write_csr(CSR_JITTER, 12'd12);
      random_points(300);
      drain_results();
      write_csr(CSR_SMOOTHING, 12'd1);
      random_points(350);
      drain_results();
      write_csr(CSR_JITTER, 12'($urandom));
      write_csr(CSR_SMOOTHING, 12'd0);
      random_points(200);
      drain_results();
      write_csr(CSR_JITTER, 12'd4095);
      random_points(200);
      drain_results();
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
